FILE: hdl/cmsrm_pkg.sv
// Shared types and constants for the compass serial read master.
// Phase codes, pin and configuration structs, result record.
// No dependencies.
`timescale 1ns / 1ps

package cmsrm_pkg;

   localparam int TIMER_W = 20;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_DEVICE_ADDRESS      = 3'd0,
      CSR_HALF_BIT_TICKS      = 3'd1,
      CSR_WAKE_TICKS          = 3'd2,
      CSR_READY_DELAY_TICKS   = 3'd3,
      CSR_READY_TIMEOUT_TICKS = 3'd4,
      CSR_POST_READY_TICKS    = 3'd5,
      CSR_END_GAP_TICKS       = 3'd6
   } csr_index_type;

   localparam logic [7:0]  RST_DEVICE_ADDRESS      = 8'd64;
   localparam logic [9:0]  RST_HALF_BIT_TICKS      = 10'd12;
   localparam logic [15:0] RST_WAKE_TICKS          = 16'd2000;
   localparam logic [15:0] RST_READY_DELAY_TICKS   = 16'd10000;
   localparam logic [19:0] RST_READY_TIMEOUT_TICKS = 20'h10000;
   localparam logic [15:0] RST_POST_READY_TICKS    = 16'd30000;
   localparam logic [9:0]  RST_END_GAP_TICKS       = 10'd110;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'd0,
      PH_PREP       = 5'd1,
      PH_WAKE       = 5'd2,
      PH_SDLOW      = 5'd3,
      PH_SCLOW      = 5'd4,
      PH_SCHIGH     = 5'd5,
      PH_SDHIGH     = 5'd6,
      PH_SCLOW2     = 5'd7,
      PH_CMD_HIGH   = 5'd8,
      PH_CMD_LOW    = 5'd9,
      PH_ACK_HIGH   = 5'd10,
      PH_ACK_LOW    = 5'd11,
      PH_RDELAY     = 5'd12,
      PH_POLL       = 5'd13,
      PH_POST       = 5'd14,
      PH_PULSE_HIGH = 5'd15,
      PH_PULSE_LOW  = 5'd16,
      PH_RD_HIGH    = 5'd17,
      PH_RD_LOW     = 5'd18,
      PH_MACK_HIGH  = 5'd19,
      PH_MACK_LOW   = 5'd20,
      PH_END_GAP    = 5'd21
   } phase_type;

   typedef struct packed {
      logic oe;
      logic sda;
      logic scl;
   } pin_type;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [9:0]  half_bit_ticks;
      logic [15:0] wake_ticks;
      logic [15:0] ready_delay_ticks;
      logic [19:0] ready_timeout_ticks;
      logic [15:0] post_ready_ticks;
      logic [9:0]  end_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic        scl;
      logic        sda_out;
      logic        sda_oe;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_value;
      logic [7:0]  checksum;
      logic        ack_error;
      logic        timeout_error;
   } rsp_type;

endpackage

FILE: hdl/cmsrm_csr.sv
// Configuration register file for the compass serial read master.
// Uses cmsrm_pkg for register indexes, reset values and the cfg struct.
`timescale 1ns / 1ps

module cmsrm_csr import cmsrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:      cfg_in.device_address      = csr_wdata[7:0];
            CSR_HALF_BIT_TICKS:      cfg_in.half_bit_ticks      = csr_wdata[9:0];
            CSR_WAKE_TICKS:          cfg_in.wake_ticks          = csr_wdata[15:0];
            CSR_READY_DELAY_TICKS:   cfg_in.ready_delay_ticks   = csr_wdata[15:0];
            CSR_READY_TIMEOUT_TICKS: cfg_in.ready_timeout_ticks = csr_wdata[19:0];
            CSR_POST_READY_TICKS:    cfg_in.post_ready_ticks    = csr_wdata[15:0];
            CSR_END_GAP_TICKS:       cfg_in.end_gap_ticks       = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address      <= RST_DEVICE_ADDRESS;
         cfg_ff.half_bit_ticks      <= RST_HALF_BIT_TICKS;
         cfg_ff.wake_ticks          <= RST_WAKE_TICKS;
         cfg_ff.ready_delay_ticks   <= RST_READY_DELAY_TICKS;
         cfg_ff.ready_timeout_ticks <= RST_READY_TIMEOUT_TICKS;
         cfg_ff.post_ready_ticks    <= RST_POST_READY_TICKS;
         cfg_ff.end_gap_ticks       <= RST_END_GAP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/cmsrm_seq.sv
// Link sequencer: phase, timer, counters and shift registers, one step per transaction.
// Uses cmsrm_pkg for phase codes, pin, cfg and result types.
`timescale 1ns / 1ps

module cmsrm_seq import cmsrm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       func,
   input  logic [7:0] cmd_code,
   input  logic       sda_in,
   input  cfg_type    cfg,
   output rsp_type    rsp
);

   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [1:0]         byte_cnt_ff, byte_cnt_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [15:0]        value_ff, value_in;
   logic [7:0]         chk_ff, chk_in;
   logic [1:0]         err_ff, err_in;
   pin_type            pins_ff, pins_in;
   logic               done;

   logic [TIMER_W-1:0] half;
   logic [TIMER_W:0]   poll_cnt;
   logic [3:0]         bit_next;

   assign half     = TIMER_W'(cfg.half_bit_ticks);
   assign poll_cnt = {1'b0, timer_ff} + (TIMER_W+1)'(1);
   assign bit_next = bit_cnt_ff + 4'd1;

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      chk_in      = chk_ff;
      err_in      = err_ff;
      pins_in     = pins_ff;
      done        = 1'b0;

      if (func) begin
         if (phase_ff == PH_IDLE) begin
            err_in      = 2'b00;
            value_in    = '0;
            chk_in      = '0;
            bit_cnt_in  = '0;
            byte_cnt_in = '0;
            cmd_in      = cmd_code | cfg.device_address | 8'h01;
            phase_in    = PH_PREP;
            pins_in     = '{oe: 1'b1, sda: 1'b1, scl: 1'b0};
            timer_in    = TIMER_W'(1);
         end
      end else if (phase_ff == PH_POLL) begin
         if (!sda_in) begin
            phase_in = PH_POST;
            pins_in  = '0;
            timer_in = TIMER_W'(cfg.post_ready_ticks);
         end else if (poll_cnt >= {1'b0, cfg.ready_timeout_ticks}) begin
            // give up: end the transaction on this tick
            err_in[1] = 1'b1;
            done      = 1'b1;
            phase_in  = PH_IDLE;
            pins_in   = '0;
            timer_in  = '0;
         end else begin
            timer_in = poll_cnt[TIMER_W-1:0];
         end
      end else if (phase_ff != PH_IDLE) begin
         if (timer_ff > TIMER_W'(1)) begin
            timer_in = timer_ff - TIMER_W'(1);
         end else begin
            timer_in = half;
            case (phase_ff)
               PH_PREP: begin
                  phase_in = PH_WAKE;
                  pins_in  = '{oe: 1'b1, sda: 1'b1, scl: 1'b1};
                  timer_in = TIMER_W'(cfg.wake_ticks);
               end
               PH_WAKE: begin
                  phase_in = PH_SDLOW;
                  pins_in  = '{oe: 1'b1, sda: 1'b0, scl: 1'b1};
               end
               PH_SDLOW: begin
                  phase_in = PH_SCLOW;
                  pins_in  = '{oe: 1'b1, sda: 1'b0, scl: 1'b0};
               end
               PH_SCLOW: begin
                  phase_in = PH_SCHIGH;
                  pins_in  = '{oe: 1'b1, sda: 1'b0, scl: 1'b1};
               end
               PH_SCHIGH: begin
                  phase_in = PH_SDHIGH;
                  pins_in  = '{oe: 1'b1, sda: 1'b1, scl: 1'b1};
               end
               PH_SDHIGH: begin
                  phase_in = PH_SCLOW2;
                  pins_in  = '{oe: 1'b1, sda: 1'b1, scl: 1'b0};
               end
               PH_SCLOW2: begin
                  bit_cnt_in = '0;
                  phase_in   = PH_CMD_HIGH;
                  pins_in    = '{oe: 1'b1, sda: cmd_ff[7], scl: 1'b1};
                  cmd_in     = {cmd_ff[6:0], 1'b0};
               end
               PH_CMD_HIGH: begin
                  phase_in    = PH_CMD_LOW;
                  pins_in.scl = 1'b0;
               end
               PH_CMD_LOW: begin
                  bit_cnt_in = bit_next;
                  if (bit_next < 4'd8) begin
                     phase_in = PH_CMD_HIGH;
                     pins_in  = '{oe: 1'b1, sda: cmd_ff[7], scl: 1'b1};
                     cmd_in   = {cmd_ff[6:0], 1'b0};
                  end else begin
                     phase_in = PH_ACK_HIGH;
                     pins_in  = '{oe: 1'b0, sda: 1'b0, scl: 1'b1};
                  end
               end
               PH_ACK_HIGH: begin
                  if (sda_in) begin
                     err_in[0] = 1'b1;
                  end
                  phase_in = PH_ACK_LOW;
                  pins_in  = '0;
               end
               PH_ACK_LOW: begin
                  phase_in = PH_RDELAY;
                  pins_in  = '0;
                  timer_in = TIMER_W'(cfg.ready_delay_ticks);
               end
               PH_RDELAY: begin
                  phase_in = PH_POLL;
                  pins_in  = '0;
                  timer_in = '0;
               end
               PH_POST: begin
                  phase_in = PH_PULSE_HIGH;
                  pins_in  = '{oe: 1'b0, sda: 1'b0, scl: 1'b1};
               end
               PH_PULSE_HIGH: begin
                  phase_in = PH_PULSE_LOW;
                  pins_in  = '0;
               end
               PH_PULSE_LOW: begin
                  bit_cnt_in  = '0;
                  byte_cnt_in = '0;
                  phase_in    = PH_RD_HIGH;
                  pins_in     = '{oe: 1'b0, sda: 1'b0, scl: 1'b1};
               end
               PH_RD_HIGH: begin
                  // sample at the end of the clock-high phase
                  if (byte_cnt_ff < 2'd2) begin
                     value_in = {value_ff[14:0], sda_in};
                  end else begin
                     chk_in = {chk_ff[6:0], sda_in};
                  end
                  phase_in = PH_RD_LOW;
                  pins_in  = '0;
               end
               PH_RD_LOW: begin
                  bit_cnt_in = bit_next;
                  if (bit_next < 4'd8) begin
                     phase_in = PH_RD_HIGH;
                     pins_in  = '{oe: 1'b0, sda: 1'b0, scl: 1'b1};
                  end else begin
                     phase_in = PH_MACK_HIGH;
                     pins_in  = '{oe: 1'b1, sda: (byte_cnt_ff >= 2'd2), scl: 1'b1};
                  end
               end
               PH_MACK_HIGH: begin
                  if (byte_cnt_ff >= 2'd2) begin
                     phase_in = PH_END_GAP;
                     pins_in  = '{oe: 1'b1, sda: 1'b1, scl: 1'b0};
                     timer_in = TIMER_W'(cfg.end_gap_ticks);
                  end else begin
                     phase_in = PH_MACK_LOW;
                     pins_in  = '{oe: 1'b1, sda: 1'b0, scl: 1'b0};
                  end
               end
               PH_MACK_LOW: begin
                  byte_cnt_in = byte_cnt_ff + 2'd1;
                  bit_cnt_in  = '0;
                  phase_in    = PH_RD_HIGH;
                  pins_in     = '{oe: 1'b0, sda: 1'b0, scl: 1'b1};
               end
               PH_END_GAP: begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
                  pins_in  = '0;
                  timer_in = '0;
               end
               default: begin
                  phase_in = PH_IDLE;
                  pins_in  = '0;
                  timer_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         bit_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         cmd_ff      <= '0;
         value_ff    <= '0;
         chk_ff      <= '0;
         err_ff      <= '0;
         pins_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         cmd_ff      <= cmd_in;
         value_ff    <= value_in;
         chk_ff      <= chk_in;
         err_ff      <= err_in;
         pins_ff     <= pins_in;
      end
   end

   always_comb begin
      rsp.scl           = pins_in.scl;
      rsp.sda_out       = pins_in.oe & pins_in.sda;
      rsp.sda_oe        = pins_in.oe;
      rsp.busy_res      = (phase_in != PH_IDLE);
      rsp.done_res      = done;
      rsp.read_value    = value_in;
      rsp.checksum      = chk_in;
      rsp.ack_error     = err_in[0];
      rsp.timeout_error = err_in[1];
   end

endmodule

FILE: hdl/compass_serial_read_master_unit.sv
// Top level of the compass serial read master: config registers, sequencer, result register.
// Depends on cmsrm_pkg, cmsrm_csr and cmsrm_seq.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  func, cmd_code, sda_in
//   rsp      out        rsp_valid / rsp_stall  pins, busy, done, value, checksum, errors
//   csr      in         csr_we                 csr_index, csr_wdata
//
// The sequencer state steps on acceptance and the result lands in the output register at
// the same edge, so a new request is taken every cycle while the result register is empty
// or being drained.
// Synchronous reset returns the sequencer to idle and the config registers to defaults.
// A stalled result holds the register and stalls the request side.
`timescale 1ns / 1ps

module compass_serial_read_master_unit import cmsrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_cmd_code,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl,
   output logic        rsp_sda_out,
   output logic        rsp_sda_oe,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [15:0] rsp_read_value,
   output logic [7:0]  rsp_checksum,
   output logic        rsp_ack_error,
   output logic        rsp_timeout_error,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   cmsrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cmsrm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .func     (req_func),
      .cmd_code (req_cmd_code),
      .sda_in   (req_sda_in),
      .cfg      (cfg),
      .rsp      (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl           = rsp_ff.scl;
   assign rsp_sda_out       = rsp_ff.sda_out;
   assign rsp_sda_oe        = rsp_ff.sda_oe;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_read_value    = rsp_ff.read_value;
   assign rsp_checksum      = rsp_ff.checksum;
   assign rsp_ack_error     = rsp_ff.ack_error;
   assign rsp_timeout_error = rsp_ff.timeout_error;

endmodule

FILE: hdl/cmsrm_checker.sv
// Port-level checks for the compass serial read master, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module cmsrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_sda_out,
   input logic        rsp_sda_oe,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [15:0] rsp_read_value,
   input logic [7:0]  rsp_checksum,
   input logic        rsp_timeout_error
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_done_res))
      else $error("stalled result changed");

   // every accepted request yields a result on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done while busy");

   a_input_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_oe |-> !rsp_sda_out)
      else $error("data driven high in input mode");

   // timeout ends the transfer before any data bit is shifted in
   a_timeout_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timeout_error |-> rsp_read_value == 16'd0 && rsp_checksum == 8'd0)
      else $error("data present after timeout");

endmodule

bind compass_serial_read_master_unit cmsrm_checker u_cmsrm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_sda_out       (rsp_sda_out),
   .rsp_sda_oe        (rsp_sda_oe),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_done_res      (rsp_done_res),
   .rsp_read_value    (rsp_read_value),
   .rsp_checksum      (rsp_checksum),
   .rsp_timeout_error (rsp_timeout_error)
);

FILE: tb/sv/compass_serial_read_master_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for compass_serial_read_master_unit: directed and random tick/start transactions,
// each result compared field by field with a cycle-level model of the link sequencer.
// Depends on cmsrm_pkg and the unit's RTL.

module compass_serial_read_master_unit_tb;
   import cmsrm_pkg::*;

   localparam int HANG_LIMIT = 2000;
   localparam int RANDOM_OPS = 1300;

   typedef struct packed {
      logic       func;
      logic [7:0] code;
      logic       sda;
   } link_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_cmd_code = 8'd0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl;
   logic        rsp_sda_out;
   logic        rsp_sda_oe;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [15:0] rsp_read_value;
   logic [7:0]  rsp_checksum;
   logic        rsp_ack_error;
   logic        rsp_timeout_error;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_DEVICE_ADDRESS;
   logic [19:0] csr_wdata = 20'd0;

   compass_serial_read_master_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the sequencer: configuration, state and pins
   cfg_type     lk_cfg;
   phase_type   lk_phase;
   logic [19:0] lk_timer;
   logic [3:0]  lk_bits;
   logic [1:0]  lk_bytes;
   logic [7:0]  lk_cmd;
   logic [15:0] lk_value;
   logic [7:0]  lk_csum;
   logic        lk_ack_err;
   logic        lk_tmo_err;
   pin_type     lk_pins;

   link_op_type op_queue[$];
   rsp_type     link_out_q[$];
   int          ops_pushed = 0;
   int          ops_taken = 0;
   int          outs_seen = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 14;
   int          recv_stall_pct = 55;
   logic        req_took = 1'b0;
   logic        hung = 1'b0;

   function automatic pin_type pin_set(logic c, logic d, logic e);
      pin_type p;
      p.scl = c;
      p.sda = d;
      p.oe = e;
      return p;
   endfunction

   function automatic void lk_go(phase_type p, pin_type pins, logic [19:0] dur);
      lk_phase = p;
      lk_pins = pins;
      lk_timer = dur;
   endfunction

   function automatic void lk_reset();
      lk_cfg.device_address = RST_DEVICE_ADDRESS;
      lk_cfg.half_bit_ticks = RST_HALF_BIT_TICKS;
      lk_cfg.wake_ticks = RST_WAKE_TICKS;
      lk_cfg.ready_delay_ticks = RST_READY_DELAY_TICKS;
      lk_cfg.ready_timeout_ticks = RST_READY_TIMEOUT_TICKS;
      lk_cfg.post_ready_ticks = RST_POST_READY_TICKS;
      lk_cfg.end_gap_ticks = RST_END_GAP_TICKS;
      lk_phase = PH_IDLE;
      lk_timer = '0;
      lk_bits = '0;
      lk_bytes = '0;
      lk_cmd = '0;
      lk_value = '0;
      lk_csum = '0;
      lk_ack_err = 1'b0;
      lk_tmo_err = 1'b0;
      lk_pins = '0;
   endfunction

   function automatic void lk_write(logic [2:0] idx, logic [19:0] val);
      case (csr_index_type'(idx))
         CSR_DEVICE_ADDRESS:      lk_cfg.device_address = val[7:0];
         CSR_HALF_BIT_TICKS:      lk_cfg.half_bit_ticks = val[9:0];
         CSR_WAKE_TICKS:          lk_cfg.wake_ticks = val[15:0];
         CSR_READY_DELAY_TICKS:   lk_cfg.ready_delay_ticks = val[15:0];
         CSR_READY_TIMEOUT_TICKS: lk_cfg.ready_timeout_ticks = val;
         CSR_POST_READY_TICKS:    lk_cfg.post_ready_ticks = val[15:0];
         CSR_END_GAP_TICKS:       lk_cfg.end_gap_ticks = val[9:0];
         default: ;
      endcase
   endfunction

   // Shift the next command bit onto the data pin with the clock high
   function automatic void lk_send_bit();
      logic b;
      b = lk_cmd[7];
      lk_cmd = {lk_cmd[6:0], 1'b0};
      lk_go(PH_CMD_HIGH, pin_set(1'b1, b, 1'b1), {10'd0, lk_cfg.half_bit_ticks});
   endfunction

   // Leave the current phase once its timer has run out; returns the done pulse
   function automatic logic lk_advance(logic sda);
      logic [19:0] h;
      logic        done;
      h = {10'd0, lk_cfg.half_bit_ticks};
      done = 1'b0;
      case (lk_phase)
         PH_PREP:   lk_go(PH_WAKE, pin_set(1'b1, 1'b1, 1'b1), {4'd0, lk_cfg.wake_ticks});
         PH_WAKE:   lk_go(PH_SDLOW, pin_set(1'b1, 1'b0, 1'b1), h);
         PH_SDLOW:  lk_go(PH_SCLOW, pin_set(1'b0, 1'b0, 1'b1), h);
         PH_SCLOW:  lk_go(PH_SCHIGH, pin_set(1'b1, 1'b0, 1'b1), h);
         PH_SCHIGH: lk_go(PH_SDHIGH, pin_set(1'b1, 1'b1, 1'b1), h);
         PH_SDHIGH: lk_go(PH_SCLOW2, pin_set(1'b0, 1'b1, 1'b1), h);
         PH_SCLOW2: begin
            lk_bits = '0;
            lk_send_bit();
         end
         PH_CMD_HIGH: lk_go(PH_CMD_LOW, pin_set(1'b0, lk_pins.sda, lk_pins.oe), h);
         PH_CMD_LOW: begin
            lk_bits = lk_bits + 4'd1;
            if (lk_bits < 4'd8) begin
               lk_send_bit();
            end else begin
               lk_go(PH_ACK_HIGH, pin_set(1'b1, 1'b0, 1'b0), h);
            end
         end
         PH_ACK_HIGH: begin
            if (sda) lk_ack_err = 1'b1;
            lk_go(PH_ACK_LOW, pin_set(1'b0, 1'b0, 1'b0), h);
         end
         PH_ACK_LOW: lk_go(PH_RDELAY, '0, {4'd0, lk_cfg.ready_delay_ticks});
         PH_RDELAY:  lk_go(PH_POLL, '0, '0);
         PH_POST:    lk_go(PH_PULSE_HIGH, pin_set(1'b1, 1'b0, 1'b0), h);
         PH_PULSE_HIGH: lk_go(PH_PULSE_LOW, '0, h);
         PH_PULSE_LOW: begin
            lk_bits = '0;
            lk_bytes = '0;
            lk_go(PH_RD_HIGH, pin_set(1'b1, 1'b0, 1'b0), h);
         end
         PH_RD_HIGH: begin
            if (lk_bytes < 2'd2) begin
               lk_value = {lk_value[14:0], sda};
            end else begin
               lk_csum = {lk_csum[6:0], sda};
            end
            lk_go(PH_RD_LOW, '0, h);
         end
         PH_RD_LOW: begin
            lk_bits = lk_bits + 4'd1;
            if (lk_bits < 4'd8) begin
               lk_go(PH_RD_HIGH, pin_set(1'b1, 1'b0, 1'b0), h);
            end else begin
               // checksum byte gets a high acknowledge, value bytes a low one
               lk_go(PH_MACK_HIGH, pin_set(1'b1, lk_bytes >= 2'd2, 1'b1), h);
            end
         end
         PH_MACK_HIGH: begin
            if (lk_bytes >= 2'd2) begin
               lk_go(PH_END_GAP, pin_set(1'b0, 1'b1, 1'b1), {10'd0, lk_cfg.end_gap_ticks});
            end else begin
               lk_go(PH_MACK_LOW, pin_set(1'b0, 1'b0, 1'b1), h);
            end
         end
         PH_MACK_LOW: begin
            lk_bytes = lk_bytes + 2'd1;
            lk_bits = '0;
            lk_go(PH_RD_HIGH, pin_set(1'b1, 1'b0, 1'b0), h);
         end
         PH_END_GAP: begin
            done = 1'b1;
            lk_go(PH_IDLE, '0, '0);
         end
         default: lk_go(PH_IDLE, '0, '0);
      endcase
      return done;
   endfunction

   function automatic rsp_type link_step(logic func, logic [7:0] code, logic sda);
      rsp_type     r;
      logic        done;
      logic [20:0] t;
      done = 1'b0;
      if (func) begin
         // a start while busy is dropped
         if (lk_phase == PH_IDLE) begin
            lk_ack_err = 1'b0;
            lk_tmo_err = 1'b0;
            lk_value = '0;
            lk_csum = '0;
            lk_bits = '0;
            lk_bytes = '0;
            lk_cmd = code | lk_cfg.device_address | 8'd1;
            lk_go(PH_PREP, pin_set(1'b0, 1'b1, 1'b1), 20'd1);
         end
      end else if (lk_phase == PH_POLL) begin
         if (!sda) begin
            lk_go(PH_POST, '0, {4'd0, lk_cfg.post_ready_ticks});
         end else begin
            t = {1'b0, lk_timer} + 21'd1;
            if (t >= {1'b0, lk_cfg.ready_timeout_ticks}) begin
               lk_tmo_err = 1'b1;
               done = 1'b1;
               lk_go(PH_IDLE, '0, '0);
            end else begin
               lk_timer = t[19:0];
            end
         end
      end else if (lk_phase != PH_IDLE) begin
         if (lk_timer > 20'd1) begin
            lk_timer = lk_timer - 20'd1;
         end else begin
            done = lk_advance(sda);
         end
      end
      r.scl = lk_pins.scl;
      r.sda_out = lk_pins.oe & lk_pins.sda;
      r.sda_oe = lk_pins.oe;
      r.busy_res = (lk_phase != PH_IDLE);
      r.done_res = done;
      r.read_value = lk_value;
      r.checksum = lk_csum;
      r.ack_error = lk_ack_err;
      r.timeout_error = lk_tmo_err;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Driver: present queued transactions, hold while stalled
   always @(negedge clock) begin : drive_ops
      link_op_type op;
      if (!reset && (!req_valid || req_took)) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op = op_queue.pop_front();
            req_valid <= 1'b1;
            req_func <= op.func;
            req_cmd_code <= op.code;
            req_sda_in <= op.sda;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor: predict on every accepted request, check every accepted result
   always @(posedge clock) begin : watch_link
      rsp_type got;
      rsp_type want;
      logic    rsp_took;
      if (reset) begin
         lk_reset();
         req_took = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_took = req_valid && !req_stall;
         rsp_took = rsp_valid && !rsp_stall;
         if (rsp_took) begin
            got = {rsp_scl, rsp_sda_out, rsp_sda_oe, rsp_busy_res, rsp_done_res,
                   rsp_read_value, rsp_checksum, rsp_ack_error, rsp_timeout_error};
            if (link_out_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, got %h", $time, got);
            end else begin
               want = link_out_q.pop_front();
               check_field("scl", 16'(want.scl), 16'(got.scl));
               check_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
               check_field("sda_oe", 16'(want.sda_oe), 16'(got.sda_oe));
               check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
               check_field("done_res", 16'(want.done_res), 16'(got.done_res));
               check_field("read_value", want.read_value, got.read_value);
               check_field("checksum", 16'(want.checksum), 16'(got.checksum));
               check_field("ack_error", 16'(want.ack_error), 16'(got.ack_error));
               check_field("timeout_error", 16'(want.timeout_error),
                           16'(got.timeout_error));
            end
            outs_seen <= outs_seen + 1;
         end
         if (req_took) begin
            link_out_q.push_back(link_step(req_func, req_cmd_code, req_sda_in));
            ops_taken <= ops_taken + 1;
         end
         if (csr_we) lk_write(csr_index, csr_wdata);
         if (req_took || rsp_took) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= HANG_LIMIT) hung = 1'b1;
      end
   end

   initial begin : hang_guard
      wait (hung);
      $display("compass_serial_read_master_unit_tb failed");
      $finish;
   end

   task automatic push_op(logic func, logic [7:0] code, logic sda);
      link_op_type op;
      op.func = func;
      op.code = code;
      op.sda = sda;
      op_queue.push_back(op);
      ops_pushed++;
   endtask

   // Wait until every pushed transaction is taken, and optionally every result drained
   task automatic wait_settled(logic all_out);
      @(posedge clock);
      while (ops_taken != ops_pushed || (all_out && outs_seen != ops_taken))
         @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [19:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_cfg(logic [7:0] addr, logic [9:0] half, logic [15:0] wake,
                           logic [15:0] rdelay, logic [19:0] tmo, logic [15:0] post,
                           logic [9:0] gap);
      wait_settled(1'b1);
      write_reg(CSR_DEVICE_ADDRESS, {12'd0, addr});
      write_reg(CSR_HALF_BIT_TICKS, {10'd0, half});
      write_reg(CSR_WAKE_TICKS, {4'd0, wake});
      write_reg(CSR_READY_DELAY_TICKS, {4'd0, rdelay});
      write_reg(CSR_READY_TIMEOUT_TICKS, tmo);
      write_reg(CSR_POST_READY_TICKS, {4'd0, post});
      write_reg(CSR_END_GAP_TICKS, {10'd0, gap});
      @(posedge clock);
   endtask

   task automatic random_cfg();
      load_cfg(8'($urandom),
               ($urandom_range(3) == 0) ? 10'($urandom_range(4, 2)) : 10'd1,
               16'($urandom_range(8, 1)), 16'($urandom_range(8)),
               20'($urandom_range(12, 1)), 16'($urandom_range(8)),
               10'($urandom_range(8)));
   endtask

   // One start (optionally doubled), then mostly ticks in chunks until the model returns to idle
   task automatic run_transfer(logic [7:0] code, int high_pct, int chunk, logic dup_start);
      int n;
      @(posedge clock);
      push_op(1'b1, code, 1'($urandom_range(1)));
      if (dup_start) push_op(1'b1, 8'($urandom), 1'($urandom_range(1)));
      do begin
         n = $urandom_range(chunk, (chunk + 1) / 2);
         repeat (n) begin
            if ($urandom_range(99) < 2) begin
               push_op(1'b1, 8'($urandom), 1'($urandom_range(1)));
            end else begin
               push_op(1'b0, 8'($urandom), $urandom_range(99) < high_pct);
            end
         end
         wait_settled(1'b0);
      end while (lk_phase != PH_IDLE);
   endtask

   initial begin : stimulus
      int base;
      int pct;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);
      // idle ticks on the reset defaults
      push_op(1'b0, 8'hFF, 1'b1);
      push_op(1'b0, 8'h00, 1'b0);
      push_op(1'b0, 8'hFF, 1'b0);
      // shortest timings: data held high gives a NAK and an immediate timeout
      load_cfg(8'h00, 10'd1, 16'd1, 16'd0, 20'd1, 16'd0, 10'd0);
      run_transfer(8'hFF, 100, 16, 1'b1);
      run_transfer(8'h00, 0, 16, 1'b0);
      run_transfer(8'hC3, 50, 16, 1'b0);
      // full address and widest timeout, short phases elsewhere
      load_cfg(8'hFF, 10'd3, 16'd5, 16'd6, 20'hFFFFF, 16'd7, 10'd9);
      run_transfer(8'h5A, 0, 16, 1'b0);
      run_transfer(8'hA5, 10, 16, 1'b0);

      base = ops_pushed;
      while (ops_pushed - base < RANDOM_OPS) begin
         if (ops_pushed - base >= 2 * RANDOM_OPS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (ops_pushed - base >= RANDOM_OPS / 3) begin
            send_idle_pct = 55;
            recv_stall_pct = 14;
         end
         if ($urandom_range(2) == 0) random_cfg();
         case ($urandom_range(3))
            0: pct = 20;
            1: pct = 80;
            default: pct = 50;
         endcase
         run_transfer(8'($urandom), pct, 16, $urandom_range(3) == 0);
      end

      wait_settled(1'b1);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && link_out_q.size() == 0) begin
         $display("compass_serial_read_master_unit_tb passed");
      end else begin
         $display("compass_serial_read_master_unit_tb failed");
      end
      $finish;
   end

endmodule
